// ===== sv/lpb_pkg.sv =====
package lpb_pkg;

  // Controller states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_TEST   = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_REM    = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // take a new bound, candidate = bound - 1
    logic next_cand;   // candidate -= 1
    logic init_div;    // divisor = 3, square = 9
    logic start_div;   // clear remainder, load dividend shifter
    logic div_step;    // one restoring-division bit
    logic next_div;    // divisor += 2, square updated
    logic set_result;  // capture result into output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic cand_lt4;
    logic cand_even;
    logic sq_gt_cand;
    logic div_last;
    logic rem_zero;
  } sts_t;

endpackage

// ===== sv/lpb_datapath.sv =====
module lpb_datapath #(
  parameter int WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lpb_pkg::cmd_t      cmd_i,
  output lpb_pkg::sts_t      sts_o,
  input  logic [WIDTH-1:0]   bound_value_i,
  output logic [WIDTH-1:0]   prime_found_o
);
  import lpb_pkg::*;

  localparam int DW  = (WIDTH + 1) / 2 + 1;  // divisor width
  localparam int SQW = WIDTH + 1;            // divisor square width
  localparam int CW  = $clog2(WIDTH);        // division bit counter

  logic [WIDTH-1:0] cand_q, cand_d;
  logic [DW-1:0]    div_q, div_d;
  logic [SQW-1:0]   sq_q, sq_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [WIDTH-1:0] sh_q, sh_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0] res_q, res_d;
  logic [DW:0]      rem_shift;
  logic [DW:0]      rem_sub;

  // Restoring division: shift in one dividend bit, subtract if it fits
  assign rem_shift = {rem_q, sh_q[WIDTH-1]};
  assign rem_sub   = rem_shift - {1'b0, div_q};

  always_comb begin
    cand_d = cand_q;
    div_d  = div_q;
    sq_d   = sq_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    res_d  = res_q;
    if (cmd_i.load) begin
      cand_d = (bound_value_i == '0) ? '0 : bound_value_i - WIDTH'(1);
    end
    if (cmd_i.next_cand) begin
      cand_d = cand_q - WIDTH'(1);
    end
    if (cmd_i.init_div) begin
      div_d = DW'(3);
      sq_d  = SQW'(9);
    end
    if (cmd_i.next_div) begin
      // (d+2)^2 = d^2 + 4d + 4
      div_d = div_q + DW'(2);
      sq_d  = sq_q + SQW'({div_q, 2'b00}) + SQW'(4);
    end
    if (cmd_i.start_div) begin
      rem_d = '0;
      sh_d  = cand_q;
      cnt_d = '0;
    end
    if (cmd_i.div_step) begin
      rem_d = (rem_shift >= {1'b0, div_q}) ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
      sh_d  = {sh_q[WIDTH-2:0], 1'b0};
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.set_result) begin
      res_d = (cand_q < WIDTH'(2)) ? '0 : cand_q;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    div_q  <= div_d;
    sq_q   <= sq_d;
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  // Status toward the controller
  assign sts_o.cand_lt4   = cand_q < WIDTH'(4);
  assign sts_o.cand_even  = ~cand_q[0];
  assign sts_o.sq_gt_cand = sq_q > {1'b0, cand_q};
  assign sts_o.div_last   = cnt_q == CW'(WIDTH - 1);
  assign sts_o.rem_zero   = rem_q == '0;

  assign prime_found_o = res_q;

`ifndef SYNTH
  // Remainder stays below divisor throughout the division
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> rem_q < div_q)
    else $error("remainder not below divisor");

  // Only odd divisors are tried
  a_div_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start_div |-> div_q[0])
    else $error("even trial divisor");

  // Captured result is zero or at least two
  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.set_result |=> (res_q == '0) || (res_q >= WIDTH'(2)))
    else $error("result is one");
`endif

endmodule

// ===== sv/lpb_ctrl.sv =====
module lpb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lpb_pkg::cmd_t cmd_o,
  input  lpb_pkg::sts_t sts_i
);
  import lpb_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Sequencer: candidate loop around the divisor loop
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.cand_lt4) begin
          state_d = ST_FINISH;
        end else if (sts_i.cand_even) begin
          cmd_o.next_cand = 1'b1;
        end else begin
          cmd_o.init_div = 1'b1;
          state_d        = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts_i.sq_gt_cand) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.start_div = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_REM;
        end
      end
      ST_REM: begin
        if (sts_i.rem_zero) begin
          cmd_o.next_cand = 1'b1;
          state_d         = ST_CHECK;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = ST_TEST;
        end
      end
      ST_FINISH: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.set_result = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.set_result |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten");

  // Capturing a result always raises out_valid next cycle
  a_set_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.set_result |=> out_valid_q)
    else $error("result captured without valid");

  // Each division runs its full length before the remainder is judged
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REM) |-> ($past(state_q) == ST_DIV) && $past(sts_i.div_last))
    else $error("division cut short");
`endif

endmodule

// ===== sv/largest_prime_below_top.sv =====
// Channel | Handshake               | Payload
// --------+-------------------------+------------------------
// in      | in_valid_i / in_ready_o | bound_value_i [WIDTH]
// out     | out_valid_o/out_ready_i | prime_found_o [WIDTH]
//
// One item at a time. Each trial divisor runs a test, WIDTH restoring-division
// steps in a one-bit-per-cycle divider, and a remainder check; each candidate
// adds a check of its range and parity. Total time is data dependent: it grows
// with the candidates tried and with the divisors tried for each of them.
// Reset is asynchronous, active low; it clears the controller and out_valid.
// A stalled result sits in the output register while the next bound is taken.
module largest_prime_below_top #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] bound_value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] prime_found_o
);
  import lpb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lpb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lpb_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .bound_value_i (bound_value_i),
    .prime_found_o (prime_found_o)
  );

endmodule
